// ----- rtl/mm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// Shared widths, defaults and the types that travel between the matrix
// multiplier's top level and its row of multiply-accumulate cells.
// ----------------------------------------------------------------------------
package mm_pkg;

  // element, result and dimension widths and the default size
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 35;
  localparam int DIM_W       = 4;
  localparam int MAX_DIM_DEF = 8;

  // dimension register value after reset
  localparam logic [DIM_W-1:0] DIM_RST = 4'd8;

  // operand beat that walks down the cell row
  typedef struct packed {
    logic                     v;
    logic                     first;
    logic                     last;
    logic signed [ELEM_W-1:0] a;
  } mm_tap_t;

  // result register controls broadcast to every cell
  typedef struct packed {
    logic ld;
    logic shift;
  } mm_ctl_t;

endpackage

// ----- rtl/mm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_in_if
// Element channel: one signed Q8.8 matrix element per beat.
// ----------------------------------------------------------------------------
interface mm_in_if import mm_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);

endinterface

// ----- rtl/mm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_out_if
// Product channel: one product element per beat, last marks the final one.
// ----------------------------------------------------------------------------
interface mm_out_if import mm_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product;
  logic                     last;

  modport source (output valid, output product, output last, input ready);
  modport sink   (input valid, input product, input last, output ready);

endinterface

// ----- rtl/mm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_cell
// One column cell: holds one column of the right matrix, multiplies the
// left operand passing by with its column entry, accumulates the dot
// product and forwards the operand to its neighbor in the next cycle.
// ----------------------------------------------------------------------------
module mm_cell import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [$clog2(MAX_DIM)-1:0]       wr_row,
  input  logic signed [ELEM_W-1:0]         wr_data,
  input  mm_tap_t                          tap_in,
  output mm_tap_t                          tap_out,
  input  mm_ctl_t                          ctl,
  input  logic signed [PROD_W-1:0]         sh_in,
  output logic signed [PROD_W-1:0]         sh_out,
  output logic                             done
);

  localparam int KW  = $clog2(MAX_DIM);
  localparam int MW  = 2 * ELEM_W;

  logic signed [ELEM_W-1:0] col_r [MAX_DIM];
  mm_tap_t                  tap_r;
  logic [KW-1:0]            kidx_r;
  logic signed [MW-1:0]     prod_r;
  logic                     pv_r;
  logic                     pfirst_r;
  logic                     plast_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] prod_ext;
  logic                     done_r;
  logic signed [PROD_W-1:0] sh_r;

  // column store of the right matrix
  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_r[wr_row] <= wr_data;
    end
  end

  // operand stage, also the hand-off to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= '0;
      kidx_r <= '0;
    end else begin
      tap_r <= tap_in;
      if (tap_in.v) begin
        kidx_r <= tap_in.first ? '0 : kidx_r + KW'(1);
      end
    end
  end

  assign tap_out = tap_r;

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= 1'b0;
      pfirst_r <= 1'b0;
      plast_r  <= 1'b0;
    end else begin
      pv_r     <= tap_r.v;
      pfirst_r <= tap_r.first;
      plast_r  <= tap_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= tap_r.a * col_r[kidx_r];
  end

  assign prod_ext = {{(PROD_W - MW){prod_r[MW-1]}}, prod_r};

  // accumulate stage
  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_r <= pfirst_r ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= pv_r && plast_r;
    end
  end

  assign done = done_r;

  // result shift chain toward cell zero
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      sh_r <= acc_r;
    end else if (ctl.shift) begin
      sh_r <= sh_in;
    end
  end

  assign sh_out = sh_r;

endmodule

// ----- rtl/square_matrix_multiply.sv -----
`timescale 1ns / 1ps
// Loading: one element beat per cycle while valid is held, 2*n*n beats per matrix pair.
// Each product row is issued, read from the RAM, passed down the cell row and summed in
// the accumulators, then leaves as n output beats.
// The operand walk down the row of MAX_DIM cells sets the per-row latency.
// Reset: dimension 8, load count zero; the matrix stores are not cleared.
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Square matrix multiplier: left matrix held in a RAM, right matrix spread
// over a row of column cells, one product row computed at a time.
// ----------------------------------------------------------------------------
module square_matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [DIM_W-1:0] cfg_wr_data,
  mm_in_if.sink            in_ch,
  mm_out_if.source         out_ch
);

  localparam int KW    = $clog2(MAX_DIM);
  localparam int NW    = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_UNLOAD = 4'b1000
  } st_t;

  st_t              st_r, st_nxt;
  logic [DIM_W-1:0] dim_r, dim_nxt;
  logic             phase_r, phase_nxt;
  logic [KW-1:0]    li_r, li_nxt;
  logic [KW-1:0]    lj_r, lj_nxt;
  logic [AW-1:0]    wad_r, wad_nxt;
  logic [AW-1:0]    rd_r, rd_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    row_r, row_nxt;
  logic [NW-1:0]    ocnt_r, ocnt_nxt;
  mm_tap_t          iss_r, iss_nxt;
  mm_ctl_t          ctl;

  logic [NW-1:0]    n_act;
  logic [KW-1:0]    nm1;
  logic             in_acc;
  logic             out_acc;
  logic [ELEM_W-1:0] ram_rdata;
  logic [MAX_DIM-1:0] cell_we;
  logic [MAX_DIM-1:0] cell_done;

  mm_tap_t                  tap [MAX_DIM+1];
  logic signed [PROD_W-1:0] sh  [MAX_DIM+1];

  // active dimension: zero reads as one, large values saturate
  always_comb begin
    if (dim_r == '0) begin
      n_act = NW'(1);
    end else if (32'(dim_r) > MAX_DIM) begin
      n_act = NW'(MAX_DIM);
    end else begin
      n_act = NW'(dim_r);
    end
  end

  assign nm1 = KW'(n_act - NW'(1));

  // handshakes
  assign in_ch.ready    = (st_r == ST_LOAD);
  assign in_acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = (st_r == ST_UNLOAD);
  assign out_ch.product = sh[0];
  assign out_ch.last    = (st_r == ST_UNLOAD) && (ocnt_r == NW'(1)) && (row_r == nm1);
  assign out_acc        = out_ch.valid && out_ch.ready;

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    dim_nxt   = dim_r;
    phase_nxt = phase_r;
    li_nxt    = li_r;
    lj_nxt    = lj_r;
    wad_nxt   = wad_r;
    rd_nxt    = rd_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    ocnt_nxt  = ocnt_r;
    iss_nxt   = '0;
    ctl       = '0;

    unique case (st_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (!phase_r) begin
            wad_nxt = wad_r + AW'(1);
          end
          if (lj_r == nm1) begin
            lj_nxt = '0;
            if (li_r == nm1) begin
              li_nxt    = '0;
              wad_nxt   = '0;
              phase_nxt = ~phase_r;
              if (phase_r) begin
                st_nxt  = ST_ISSUE;
                rd_nxt  = '0;
                k_nxt   = '0;
                row_nxt = '0;
              end
            end else begin
              li_nxt = li_r + KW'(1);
            end
          end else begin
            lj_nxt = lj_r + KW'(1);
          end
        end
      end
      ST_ISSUE: begin
        iss_nxt.v     = 1'b1;
        iss_nxt.first = (k_r == '0);
        iss_nxt.last  = (k_r == nm1);
        rd_nxt        = rd_r + AW'(1);
        if (k_r == nm1) begin
          k_nxt  = '0;
          st_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      ST_DRAIN: begin
        if (cell_done[MAX_DIM-1]) begin
          ctl.ld   = 1'b1;
          ocnt_nxt = n_act;
          st_nxt   = ST_UNLOAD;
        end
      end
      ST_UNLOAD: begin
        if (out_acc) begin
          ctl.shift = 1'b1;
          ocnt_nxt  = ocnt_r - NW'(1);
          if (ocnt_r == NW'(1)) begin
            if (row_r == nm1) begin
              st_nxt = ST_LOAD;
            end else begin
              row_nxt = row_r + KW'(1);
              st_nxt  = ST_ISSUE;
            end
          end
        end
      end
      default: begin
        st_nxt = ST_LOAD;
      end
    endcase

    // dimension write restarts loading
    if (cfg_wr_en) begin
      dim_nxt   = cfg_wr_data;
      phase_nxt = 1'b0;
      li_nxt    = '0;
      lj_nxt    = '0;
      wad_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_LOAD;
      dim_r   <= DIM_RST;
      phase_r <= 1'b0;
      li_r    <= '0;
      lj_r    <= '0;
      wad_r   <= '0;
      rd_r    <= '0;
      k_r     <= '0;
      row_r   <= '0;
      ocnt_r  <= '0;
      iss_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      dim_r   <= dim_nxt;
      phase_r <= phase_nxt;
      li_r    <= li_nxt;
      lj_r    <= lj_nxt;
      wad_r   <= wad_nxt;
      rd_r    <= rd_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      ocnt_r  <= ocnt_nxt;
      iss_r   <= iss_nxt;
    end
  end

  // left matrix store
  mm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_left (
    .clk   (clk),
    .we    (in_acc && !phase_r),
    .waddr (wad_r),
    .wdata (in_ch.element),
    .raddr (rd_r),
    .rdata (ram_rdata)
  );

  // operand enters the cell row aligned with the RAM read data
  always_comb begin
    tap[0]       = iss_r;
    tap[0].a     = $signed(ram_rdata);
  end

  assign sh[MAX_DIM] = '0;

  // row of column cells
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    assign cell_we[j] = in_acc && phase_r && (lj_r == KW'(j));

    mm_cell #(
      .MAX_DIM (MAX_DIM)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (cell_we[j]),
      .wr_row  (li_r),
      .wr_data (in_ch.element),
      .tap_in  (tap[j]),
      .tap_out (tap[j+1]),
      .ctl     (ctl),
      .sh_in   (sh[j+1]),
      .sh_out  (sh[j]),
      .done    (cell_done[j])
    );
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("element and product channels active together");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cell_done[MAX_DIM-1] |-> (st_r == ST_DRAIN))
    else $error("row completion outside drain");

  a_last_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.last) |=> in_ch.ready)
    else $error("no return to loading after final product");

  a_unload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UNLOAD) |-> (ocnt_r != '0))
    else $error("unloading with empty count");

endmodule
